// ===== hdl/aspc_pkg.sv =====
// package: types, constants and crc function for the audio sample packetizer
package aspc_pkg;

  localparam int MAX_SLOTS_DEFAULT = 32;
  localparam int CMD_DEPTH = 2;

  localparam logic [31:0] HDR_FIRST_WORD = 32'h2440FFFF;
  localparam logic [31:0] CRC_SEED_INV   = 32'h2144DF1C;
  localparam logic [31:0] CRC_POLY_REFL  = 32'hEDB88320;

  localparam logic REG_SLOTS_PER_PACKET = 1'b0;
  localparam logic REG_QUEUE_PAIR       = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_CRC    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [23:0] sample;
    logic        end_of_audio;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  word_kind;
    logic        last_of_packet;
  } result_t;

  typedef struct packed {
    logic [23:0] sample;
    logic        open_pkt;
    logic        close_pkt;
    logic [5:0]  fill_count;
    logic [23:0] queue_pair;
  } cmd_t;

  // reflected crc-32 over four bytes, first byte in bits 31:24, lsb first
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int b = 0; b < 4; b++) begin
      for (int j = 0; j < 8; j++) begin
        fb = c[0] ^ w[24 - 8 * b + j];
        c  = (c >> 1) ^ (fb ? CRC_POLY_REFL : 32'h0);
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/audio_sample_packetizer_crc32.sv =====
// top level: audio sample packetizer with crc-32 trailer
//
//   port group                       dir  handshake         payload
//   push / full / item               in   push & !full      item_t (sample, end_of_audio)
//   empty / pop / result             out  pop & !empty      result_t (word, kind, last)
//   cfg_write / cfg_index / cfg_data in   cfg_write         slots_per_packet, queue_pair
//
// one output word per cycle from the back-end sequencer while the output is not
// stalled; a sample passes the idle/load state, then three header words if it
// opens a packet, its payload word, and fill words and the crc word if it closes one.
// synchronous reset clears the queue, counters and sequence number and seeds the crc.
// the front stalls (full) only when the two-entry command queue is full;
// the back stalls while the output register holds a word not yet popped.
module audio_sample_packetizer_crc32 import aspc_pkg::*; #(
  parameter int MaxSlots = MAX_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       item,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_write;
  logic q_read;
  logic q_full;
  logic q_not_empty;

  assign full = q_full;

  aspc_front #(.MaxSlots(MaxSlots)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_write   (q_write),
    .cmd       (front_cmd)
  );

  aspc_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_write),
    .wr_cmd    (front_cmd),
    .rd        (q_read),
    .rd_cmd    (head_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  aspc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_read      (q_read),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

// ===== hdl/aspc_front.sv =====
// front end: config registers, slot counting and packet classification
module aspc_front import aspc_pkg::*; #(
  parameter int MaxSlots = MAX_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       item,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        q_full,
  output logic        q_write,
  output cmd_t        cmd
);

  logic [5:0]  slots_per_packet;
  logic [23:0] queue_pair;
  logic [5:0]  slot_count;
  logic [5:0]  limit;
  logic [5:0]  count_inc;
  logic        close_pkt;

  always_comb begin
    priority if (slots_per_packet == 6'd0) begin
      limit = 6'd1;
    end else if (slots_per_packet > 6'(MaxSlots)) begin
      limit = 6'(MaxSlots);
    end else begin
      limit = slots_per_packet;
    end
  end

  assign count_inc = slot_count + 6'd1;
  assign close_pkt = item.end_of_audio || (count_inc >= limit);
  assign q_write   = push && !q_full;

  always_comb begin
    cmd.sample     = item.sample;
    cmd.open_pkt   = (slot_count == 6'd0);
    cmd.close_pkt  = close_pkt;
    cmd.fill_count = (close_pkt && (limit > count_inc)) ? (limit - count_inc) : 6'd0;
    cmd.queue_pair = queue_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_packet <= 6'd32;
      queue_pair       <= 24'd2;
      slot_count       <= 6'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SLOTS_PER_PACKET: slots_per_packet <= cfg_data[5:0];
          REG_QUEUE_PAIR:       queue_pair       <= cfg_data;
        endcase
      end
      if (q_write) begin
        slot_count <= close_pkt ? 6'd0 : count_inc;
      end
    end
  end

endmodule

// ===== hdl/aspc_cmd_queue.sv =====
// short command queue between front and back end
module aspc_cmd_queue import aspc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic full,
  output logic not_empty
);

  localparam int PtrW = $clog2(CMD_DEPTH);

  cmd_t            mem [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full      = (count == (PtrW+1)'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/aspc_back.sv =====
// back end: word sequencer, crc and output register
module aspc_back import aspc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_not_empty,
  input  cmd_t    q_cmd,
  output logic    q_read,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  typedef enum logic [2:0] {
    S_IDLE, S_HDR0, S_HDR1, S_HDR2, S_PAY, S_FILL, S_CRC
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [5:0]  fill_left;
  logic [23:0] sequence_number;
  logic [31:0] crc_register;
  logic        out_valid;
  logic        adv;
  logic        emit;
  logic [31:0] pay_word;

  assign adv      = !out_valid || pop;
  assign emit     = adv && (state != S_IDLE);
  assign empty    = !out_valid;
  assign q_read   = (state == S_IDLE) && q_not_empty;
  assign pay_word = {cur.sample[7:0], cur.sample[15:8], cur.sample[23:16], 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      sequence_number <= 24'd0;
      crc_register    <= CRC_SEED_INV;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            cur       <= q_cmd;
            fill_left <= q_cmd.fill_count;
            state     <= q_cmd.open_pkt ? S_HDR0 : S_PAY;
          end
        end
        S_HDR0: begin
          if (adv) begin
            result <= '{HDR_FIRST_WORD, KIND_HEADER, 1'b0};
            state  <= S_HDR1;
          end
        end
        S_HDR1: begin
          if (adv) begin
            result <= '{{8'h00, cur.queue_pair}, KIND_HEADER, 1'b0};
            state  <= S_HDR2;
          end
        end
        S_HDR2: begin
          if (adv) begin
            result       <= '{{8'h00, sequence_number}, KIND_HEADER, 1'b0};
            crc_register <= CRC_SEED_INV;
            state        <= S_PAY;
          end
        end
        S_PAY: begin
          if (adv) begin
            result       <= '{pay_word, KIND_SAMPLE, 1'b0};
            crc_register <= crc_word(crc_register, pay_word);
            if (!cur.close_pkt) begin
              state <= S_IDLE;
            end else if (fill_left != 6'd0) begin
              state <= S_FILL;
            end else begin
              state <= S_CRC;
            end
          end
        end
        S_FILL: begin
          if (adv) begin
            result       <= '{32'h0, KIND_FILL, 1'b0};
            crc_register <= crc_word(crc_register, 32'h0);
            fill_left    <= fill_left - 6'd1;
            if (fill_left == 6'd1) begin
              state <= S_CRC;
            end
          end
        end
        S_CRC: begin
          if (adv) begin
            result          <= '{~crc_register, KIND_CRC, 1'b1};
            sequence_number <= sequence_number + 24'd1;
            crc_register    <= CRC_SEED_INV;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/audio_sample_packetizer_crc32_tb.sv =====
`timescale 1ns / 100ps
// testbench for the audio sample packetizer: directed and random samples checked word by word
module audio_sample_packetizer_crc32_tb;
  import aspc_pkg::*;

  localparam logic [31:0] OPEN_WORD   = 32'h2440FFFF;
  localparam logic [31:0] CRC_START   = 32'h2144DF1C;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam int          SLOT_CAP    = MAX_SLOTS_DEFAULT;
  localparam int          CYCLE_LIMIT = 500000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  item_t       item      = '0;
  logic        empty;
  logic        pop       = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data  = '0;

  item_t   sample_queue[$];
  result_t word_queue[$];
  result_t want;

  logic [5:0]  slots_reg;
  logic [23:0] qp_reg;
  logic [23:0] seq_num;
  int          slots_used;
  logic [31:0] crc_acc;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int samples_sent   = 0;
  int words_seen     = 0;
  int packets_seen   = 0;
  int reg_writes     = 0;
  int cycles         = 0;

  audio_sample_packetizer_crc32 dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // reflected crc-32, first byte of the word in bits 31:24
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
    logic [31:0] r;
    r = c;
    for (int b = 3; b >= 0; b--) begin
      r ^= {24'h0, w[8*b +: 8]};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void add_word(logic [31:0] w, kind_t k, logic last);
    result_t r;
    r.word           = w;
    r.word_kind      = k;
    r.last_of_packet = last;
    word_queue.push_back(r);
  endfunction

  function automatic void frame_sample(item_t it);
    int          limit;
    logic [31:0] w;
    limit = (slots_reg == 6'd0) ? 1 : (int'(slots_reg) > SLOT_CAP) ? SLOT_CAP : int'(slots_reg);
    if (slots_used == 0) begin
      add_word(OPEN_WORD, KIND_HEADER, 1'b0);
      add_word({8'h00, qp_reg}, KIND_HEADER, 1'b0);
      add_word({8'h00, seq_num}, KIND_HEADER, 1'b0);
      crc_acc = CRC_START;
    end
    w = {it.sample[7:0], it.sample[15:8], it.sample[23:16], 8'h00};
    crc_acc = crc_step(crc_acc, w);
    add_word(w, KIND_SAMPLE, 1'b0);
    slots_used++;
    if (it.end_of_audio || slots_used >= limit) begin
      while (slots_used < limit) begin
        crc_acc = crc_step(crc_acc, 32'h0);
        add_word(32'h0, KIND_FILL, 1'b0);
        slots_used++;
      end
      add_word(~crc_acc, KIND_CRC, 1'b1);
      seq_num    = seq_num + 24'd1;
      slots_used = 0;
      crc_acc    = CRC_START;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        frame_sample(item);
        void'(sample_queue.pop_front());
        samples_sent++;
      end
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= sample_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      words_seen++;
      if (result.last_of_packet) packets_seen++;
      if (word_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual %h kind %0d last %b",
                 $time, result.word, result.word_kind, result.last_of_packet);
      end else begin
        want = word_queue.pop_front();
        if (result.word !== want.word) begin
          errors++;
          $display("%0t: word: expected %h, actual %h", $time, want.word, result.word);
        end
        if (result.word_kind !== want.word_kind) begin
          errors++;
          $display("%0t: word_kind: expected %0d, actual %0d",
                   $time, want.word_kind, result.word_kind);
        end
        if (result.last_of_packet !== want.last_of_packet) begin
          errors++;
          $display("%0t: last_of_packet: expected %b, actual %b",
                   $time, want.last_of_packet, result.last_of_packet);
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, word_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_sample(logic [23:0] s, logic e);
    item_t it;
    it.sample       = s;
    it.end_of_audio = e;
    sample_queue.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || push || word_queue.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SLOTS_PER_PACKET) slots_reg = val[5:0];
    else qp_reg = val;
    reg_writes++;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] r;
    logic [5:0]  spp;
    logic [23:0] qp;
    logic [23:0] s;
    slots_reg  = 6'd32;
    qp_reg     = 24'd2;
    seq_num    = '0;
    slots_used = 0;
    crc_acc    = CRC_START;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default settings, early close and a one-sample packet
    add_sample(24'h000000, 1'b0);
    add_sample(24'hFFFFFF, 1'b0);
    add_sample(24'hA5A5A5, 1'b0);
    add_sample(24'h5A5A5A, 1'b0);
    add_sample(24'h123456, 1'b1);
    add_sample(24'hFFFFFF, 1'b1);
    wait_drained();
    write_reg(REG_QUEUE_PAIR, 24'hFFFFFF);
    write_reg(REG_SLOTS_PER_PACKET, 24'h000001);
    add_sample(24'h800001, 1'b0);
    add_sample(24'h7FFFFE, 1'b1);
    wait_drained();
    // zero slots after masking, acts as one
    write_reg(REG_SLOTS_PER_PACKET, 24'hFFFFC0);
    write_reg(REG_QUEUE_PAIR, 24'h000000);
    add_sample(24'h00FF00, 1'b1);
    add_sample(24'hFF00FF, 1'b0);
    wait_drained();
    // above the cap
    write_reg(REG_SLOTS_PER_PACKET, 24'h00003F);
    add_sample(24'h0F0F0F, 1'b0);
    add_sample(24'hF0F0F0, 1'b1);
    wait_drained();
    // shrink below what the open packet holds
    write_reg(REG_SLOTS_PER_PACKET, 24'd8);
    repeat (5) add_sample(24'($urandom()), 1'b0);
    wait_drained();
    write_reg(REG_SLOTS_PER_PACKET, 24'd3);
    add_sample(24'h111111, 1'b0);
    wait_drained();
    // shrink to exactly the next slot
    write_reg(REG_SLOTS_PER_PACKET, 24'd8);
    repeat (4) add_sample(24'($urandom()), 1'b0);
    wait_drained();
    write_reg(REG_SLOTS_PER_PACKET, 24'd5);
    add_sample(24'h222222, 1'b0);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        wait_drained();
        case ($urandom_range(5))
          0: spp = 6'd0;
          1: spp = 6'd1;
          2: spp = 6'd32;
          3: spp = 6'($urandom_range(63, 33));
          4: spp = 6'($urandom_range(4, 1));
          default: spp = 6'($urandom_range(32, 2));
        endcase
        r = $urandom();
        write_reg(REG_SLOTS_PER_PACKET, {r[17:0], spp});
        case ($urandom_range(3))
          0: qp = 24'h000000;
          1: qp = 24'hFFFFFF;
          default: qp = 24'($urandom());
        endcase
        write_reg(REG_QUEUE_PAIR, qp);
        for (int n = 0; n < 38; n++) begin
          // sender holds off until the block has drained
          if (sub == 1 && n == 19) wait_drained();
          case ($urandom_range(9))
            0: s = 24'h000000;
            1: s = 24'hFFFFFF;
            default: s = 24'($urandom());
          endcase
          add_sample(s, $urandom_range(9) == 0);
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (word_queue.size() != 0) begin
      errors += word_queue.size();
      $display("%0t: %0d expected words never arrived", $time, word_queue.size());
    end
    $display("run covered %0d samples, %0d words, %0d packets, %0d register writes",
             samples_sent, words_seen, packets_seen, reg_writes);
    $display("idle modes: none, sender, receiver, both; %0d errors", errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
